FILE: sv/lbpa_pkg.sv
// Shared types and constants for the LIFO buffer pool allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lbpa_pkg;

  localparam int unsigned LBPA_MAX_ITEMS  = 4096;
  localparam int unsigned LBPA_ITEM_BYTES = 256;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned REQ_W      = 16;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REQUESTED_ITEMS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE     = 1'b1;

  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_FILL    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_BAD_RELEASE  = 3'd2,
    ST_CLEAR_BUSY   = 3'd3,
    ST_FILL_REFUSED = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e              command;
    logic [ADDR_W-1:0] returned_address;
  } lbpa_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  buffer_address;
    status_e            status;
    logic [COUNT_W-1:0] free_count;
  } lbpa_out_t;

  // Controller to datapath
  typedef struct packed {
    logic    latch;       // capture the input item
    logic    pop;         // read top of stack, decrement depth
    logic    scale;       // register index times item size
    logic    take_addr;   // result address = base + scaled index
    logic    push;        // write released index to stack, increment depth
    logic    fill_init;   // set pool size, depth and span
    logic    fill_step;   // write one stack entry
    logic    clear;       // drop the pool
    logic    set_status;  // record result status
    status_e status;
    logic    out_load;    // move result to output register
  } lbpa_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e command;
    logic depth_zero;
    logic pool_zero;
    logic depth_full;
    logic rel_ok;
    logic fill_done;
  } lbpa_stat_t;

endpackage

`default_nettype wire

FILE: sv/lifo_buffer_pool_allocator.sv
// LIFO buffer pool allocator, top level: lbpa_ctrl sequences lbpa_dp.
// An acquire passes decode, stack read, scaling and address add; a fill writes
// one stack entry per cycle; release, clear and refused commands go from decode
// to the result. A stalled output holds the result back. One item at a time; the
// next item is taken in the cycle after its result is registered.
// Asynchronous active-low reset empties the pool, no RAM sweep.
`default_nettype none

module lifo_buffer_pool_allocator
  import lbpa_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = LBPA_MAX_ITEMS,
  parameter int unsigned ITEM_BYTES = LBPA_ITEM_BYTES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire lbpa_in_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output lbpa_out_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  lbpa_ctrl_t ctrl;
  lbpa_stat_t stat;

  lbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  lbpa_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .ITEM_BYTES (ITEM_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire

FILE: sv/lbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Uses lbpa_pkg for default sizes only.
`default_nettype none

module lbpa_ram
  import lbpa_pkg::*;
#(
  parameter int unsigned WIDTH = $clog2(LBPA_MAX_ITEMS),
  parameter int unsigned DEPTH = LBPA_MAX_ITEMS
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/lbpa_ctrl.sv
// Sequencing state machine of the buffer pool allocator.
// Depends on lbpa_pkg; drives lbpa_dp through lbpa_ctrl_t, reads lbpa_stat_t.
`default_nettype none

module lbpa_ctrl
  import lbpa_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire lbpa_stat_t stat_i,
  output lbpa_ctrl_t      ctrl_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b00_0001,
    S_DECODE  = 6'b00_0010,
    S_ACQ_RD  = 6'b00_0100,
    S_ACQ_ADD = 6'b00_1000,
    S_FILL    = 6'b01_0000,
    S_DONE    = 6'b10_0000
  } state_e;

  state_e     state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  lbpa_ctrl_t ctrl;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    ctrl        = '0;
    ctrl.status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl.latch = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (stat_i.command)
          CMD_ACQUIRE: begin
            if (stat_i.depth_zero) begin
              ctrl.set_status = 1'b1;
              ctrl.status     = ST_EMPTY;
            end else begin
              ctrl.pop = 1'b1;
              state_d  = S_ACQ_RD;
            end
          end
          CMD_RELEASE: begin
            ctrl.set_status = 1'b1;
            // push only an aligned address inside the pool with room on the stack
            if (stat_i.rel_ok) begin
              ctrl.push = 1'b1;
            end else begin
              ctrl.status = ST_BAD_RELEASE;
            end
          end
          CMD_FILL: begin
            if (!stat_i.pool_zero) begin
              ctrl.set_status = 1'b1;
              ctrl.status     = ST_FILL_REFUSED;
            end else begin
              ctrl.fill_init = 1'b1;
              state_d        = S_FILL;
            end
          end
          CMD_CLEAR: begin
            ctrl.set_status = 1'b1;
            if (stat_i.pool_zero) begin
              ctrl.status = ST_OK;
            end else if (stat_i.depth_full) begin
              ctrl.clear  = 1'b1;
              ctrl.status = ST_OK;
            end else begin
              ctrl.status = ST_CLEAR_BUSY;
            end
          end
          default: begin
            ctrl.set_status = 1'b1;
          end
        endcase
      end
      S_ACQ_RD: begin
        ctrl.scale = 1'b1;
        state_d    = S_ACQ_ADD;
      end
      S_ACQ_ADD: begin
        ctrl.take_addr  = 1'b1;
        ctrl.set_status = 1'b1;
        state_d         = S_DONE;
      end
      S_FILL: begin
        if (stat_i.fill_done) begin
          ctrl.set_status = 1'b1;
          state_d         = S_DONE;
        end else begin
          ctrl.fill_step = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign ctrl_o      = ctrl;

endmodule

`default_nettype wire

FILE: sv/lbpa_dp.sv
// Datapath of the buffer pool allocator: registers, free stack RAM, release check.
// Depends on lbpa_pkg and lbpa_ram; steered by lbpa_ctrl.
`default_nettype none

module lbpa_dp
  import lbpa_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = LBPA_MAX_ITEMS,
  parameter int unsigned ITEM_BYTES = LBPA_ITEM_BYTES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lbpa_in_t              in_data_i,
  output lbpa_out_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire lbpa_ctrl_t            ctrl_i,
  output lbpa_stat_t                 stat_o
);

  // ITEM_BYTES is a power of two: the buffer index is a slice of the offset
  localparam int unsigned IDX_W  = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IB_W   = $clog2(ITEM_BYTES + 1);
  localparam int unsigned IB_SH  = $clog2(ITEM_BYTES);
  localparam int unsigned SPAN_W = CNT_W + IB_W;
  localparam int unsigned CMP_W  = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;
  localparam int unsigned PRD_A  = IDX_W + IB_W;
  localparam int unsigned PRD_W  = (PRD_A > ADDR_W) ? PRD_A : ADDR_W;

  // configuration
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] base_q;

  // pool state
  logic [CNT_W-1:0]  depth_q, pool_q, cursor_q;
  logic [SPAN_W-1:0] span_q;

  // item and result
  cmd_e              cmd_q;
  logic [ADDR_W-1:0] ret_q;
  logic [ADDR_W-1:0] prod_q;
  logic [ADDR_W-1:0] res_addr_q;
  status_e           res_status_q;
  lbpa_out_t         out_q;

  logic [CNT_W-1:0]  fill_n;
  logic [ADDR_W-1:0] offset;
  logic              aligned;
  logic [IDX_W-1:0]  rel_idx;
  logic [PRD_W-1:0]  prd_full;
  logic [31:0]       depth_ext;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  // clamp the request to the pool capacity
  assign fill_n = (32'(req_q) > 32'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS) : CNT_W'(req_q);

  assign offset    = ret_q - base_q;
  assign aligned   = (offset[IB_SH-1:0] == '0);
  assign rel_idx   = offset[IB_SH +: IDX_W];
  assign prd_full  = PRD_W'(ram_rdata) * PRD_W'(ITEM_BYTES);
  assign depth_ext = 32'(depth_q);

  assign ram_we    = ctrl_i.push || ctrl_i.fill_step;
  assign ram_waddr = ctrl_i.push ? IDX_W'(depth_q) : IDX_W'(cursor_q);
  // fill writes indices in descending order so buffer zero ends on top
  assign ram_wdata = ctrl_i.push ? rel_idx : IDX_W'(pool_q - cursor_q - CNT_W'(1));
  assign ram_raddr = IDX_W'(depth_q - CNT_W'(1));

  lbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_ITEMS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl_i.pop),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q    <= '0;
      base_q   <= '0;
      depth_q  <= '0;
      pool_q   <= '0;
      cursor_q <= '0;
      span_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_REQUESTED_ITEMS: req_q  <= cfg_wdata_i[REQ_W-1:0];
          CFG_REGION_BASE:     base_q <= cfg_wdata_i[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (ctrl_i.clear) begin
        depth_q  <= '0;
        pool_q   <= '0;
        cursor_q <= '0;
        span_q   <= '0;
      end else if (ctrl_i.fill_init) begin
        depth_q  <= fill_n;
        pool_q   <= fill_n;
        cursor_q <= '0;
        span_q   <= SPAN_W'(fill_n) * SPAN_W'(ITEM_BYTES);
      end else begin
        if (ctrl_i.pop) begin
          depth_q <= depth_q - CNT_W'(1);
        end else if (ctrl_i.push) begin
          depth_q <= depth_q + CNT_W'(1);
        end
        if (ctrl_i.fill_step) begin
          cursor_q <= cursor_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q      <= in_data_i.command;
      ret_q      <= in_data_i.returned_address;
      res_addr_q <= '0;
    end else if (ctrl_i.take_addr) begin
      res_addr_q <= base_q + prod_q;
    end
    if (ctrl_i.scale) begin
      prod_q <= prd_full[ADDR_W-1:0];
    end
    if (ctrl_i.set_status) begin
      res_status_q <= ctrl_i.status;
    end
    if (ctrl_i.out_load) begin
      out_q.buffer_address <= res_addr_q;
      out_q.status         <= res_status_q;
      out_q.free_count     <= depth_ext[COUNT_W-1:0];
    end
  end

  assign stat_o.command    = cmd_q;
  assign stat_o.depth_zero = (depth_q == '0);
  assign stat_o.pool_zero  = (pool_q == '0);
  assign stat_o.depth_full = (depth_q == pool_q);
  assign stat_o.rel_ok     = (CMP_W'(offset) < CMP_W'(span_q)) && aligned &&
                             (depth_q < pool_q);
  assign stat_o.fill_done  = (cursor_q == pool_q);

  assign out_data_o = out_q;

endmodule

`default_nettype wire
